// ===== design/kcat_pkg.sv =====
// package for the keyed count aggregation table
// types, action and status codes, defaults shared by the table and its ram
package kcat_pkg;

    localparam int TableDepthDef = 256;
    localparam int MonthsDef     = 6;
    localparam int RepMonths     = 6;
    localparam int KeyW          = 64;
    localparam int CntW          = 32;
    localparam int TotW          = 35;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_ROUTE  = 3'd1,
        ACT_ORIGIN = 3'd2,
        ACT_DEST   = 3'd3,
        ACT_CARR   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2,
        ST_BADMO = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ADD_RD,
        S_ADD_WR,
        S_NEW_WR,
        S_SUM_RD,
        S_SUM_ACC,
        S_TOTAL,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ===== design/kcat_ram.sv =====
// generic single port synchronous ram with registered read
// no dependencies
module kcat_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/keyed_count_aggregation_table.sv =====
// keyed count aggregation table top level
// uses kcat_pkg and two kcat_ram instances (keys and monthly counts)
//
// one request enters on the s_axis channel; exactly one result leaves on m_axis.
// an add scans the stored keys from entry 0, one key per cycle, then reads and
// writes one count (or writes all months of a new entry, one per cycle).
// a search scans every used entry; for each match it reads its months, one per
// cycle, into saturating sums, then adds the sums and divides by 6 with a
// reciprocal multiply, seven bits per cycle.
// the key ram read port sets the scan rate: one entry per cycle, paused while a matching entry's months are read.
// one request at a time: s_axis_tready is high only while idle.
// the result sits in an output register until m_axis_tready; the block takes
// the next request once the result is taken.
// reset empties the table (used count to zero); no clearing pass is needed since
// only entries below the used count are ever read.
module keyed_count_aggregation_table #(
    parameter int TableDepth = kcat_pkg::TableDepthDef,
    parameter int Months     = kcat_pkg::MonthsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[2:0], origin_code[26:3], dest_code[50:27], carrier_code[66:51],
    // month[70:67], passengers[94:71], zero fill
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], entry_index[9:2], match_count[18:10], month1_sum..month6_sum
    // [210:19], grand_total[245:211], monthly_average[277:246], zero fill
    output logic [279:0] m_axis_tdata
);
    import kcat_pkg::*;

    localparam int IdxW  = $clog2(TableDepth);
    localparam int UsedW = $clog2(TableDepth + 1);
    localparam int MW    = $clog2(Months + 1);
    localparam int CDep  = TableDepth * Months;
    localparam int CAW   = $clog2(CDep);

    // divide by 6: 7-bit digits, quotient digit by multiply with 683 >> 12
    localparam int DivChunk = 7;
    localparam int DivSteps = TotW / DivChunk;
    localparam int DivDen   = 6;
    localparam int DivMul   = 683;
    localparam int DivShift = 12;

    t_state r_state, n_state;

    logic [2:0]  r_act;
    logic [23:0] r_org, r_dst, r_pax;
    logic [15:0] r_car;
    logic [3:0]  r_mon;
    logic [UsedW-1:0] r_used, n_used;
    logic [UsedW-1:0] r_i, n_i;
    logic [MW-1:0]    r_m, n_m;
    logic             r_kv, n_kv;
    logic [IdxW-1:0]  r_kidx, n_kidx;

    logic [1:0]          r_status, n_status;
    logic [7:0]          r_index, n_index;
    logic [8:0]          r_matches, n_matches;
    logic [CntW-1:0]     r_sum [RepMonths];
    logic [CntW-1:0]     n_sum [RepMonths];
    logic [TotW-1:0]     r_tot, n_tot;
    logic [2:0]          r_rem, n_rem;
    logic [TotW-1:0]     r_quo, n_quo;
    logic [5:0]          r_dc, n_dc;
    logic                r_ovalid, n_ovalid;

    logic            k_we;
    logic [IdxW-1:0] k_addr;
    logic [KeyW-1:0] k_wdata, k_rdata;
    logic            c_we;
    logic [CAW-1:0]  c_addr;
    logic [CntW-1:0] c_wdata, c_rdata;

    kcat_ram #(.Width(KeyW), .Depth(TableDepth)) u_keys (
        .i_clk(i_clk), .i_we(k_we), .i_addr(k_addr),
        .i_wdata(k_wdata), .o_rdata(k_rdata)
    );
    kcat_ram #(.Width(CntW), .Depth(CDep)) u_counts (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr),
        .i_wdata(c_wdata), .o_rdata(c_rdata)
    );

    logic [KeyW-1:0]     key;
    logic                kmatch;
    logic                mon_ok;
    logic [CAW-1:0]      ebase;
    logic [CntW:0]       sadd;
    logic [9:0]          dtry;
    logic [19:0]         dprod;
    logic [DivChunk-1:0] dq;
    logic [CntW-1:0]     cur;

    assign key    = {r_org, r_dst, r_car};
    assign mon_ok = (r_mon != 4'd0) && ({28'd0, r_mon} <= 32'(Months));
    assign ebase  = CAW'(r_kidx) * CAW'(Months);

    always_comb begin
        case (r_act)
            ACT_ADD:    kmatch = (k_rdata == key);
            ACT_ROUTE:  kmatch = (k_rdata[63:40] == r_org) && (k_rdata[39:16] == r_dst);
            ACT_ORIGIN: kmatch = (k_rdata[63:40] == r_org);
            ACT_DEST:   kmatch = (k_rdata[39:16] == r_dst);
            ACT_CARR:   kmatch = (k_rdata[15:0] == r_car);
            default:    kmatch = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_act <= s_axis_tdata[2:0];
            r_org <= s_axis_tdata[26:3];
            r_dst <= s_axis_tdata[50:27];
            r_car <= s_axis_tdata[66:51];
            r_mon <= s_axis_tdata[70:67];
            r_pax <= s_axis_tdata[94:71];
        end
        r_i       <= n_i;
        r_m       <= n_m;
        r_kv      <= n_kv;
        r_kidx    <= n_kidx;
        r_status  <= n_status;
        r_index   <= n_index;
        r_matches <= n_matches;
        r_sum     <= n_sum;
        r_tot     <= n_tot;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dc      <= n_dc;
    end

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_ovalid  = r_ovalid;
        n_i       = r_i;
        n_m       = r_m;
        n_kv      = 1'b0;
        n_kidx    = r_kidx;
        n_status  = r_status;
        n_index   = r_index;
        n_matches = r_matches;
        n_sum     = r_sum;
        n_tot     = r_tot;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_dc      = r_dc;
        k_we      = 1'b0;
        k_addr    = r_i[IdxW-1:0];
        k_wdata   = key;
        c_we      = 1'b0;
        c_addr    = ebase + CAW'(r_m);
        c_wdata   = '0;
        sadd      = '0;
        dtry      = '0;
        dprod     = '0;
        dq        = '0;
        cur       = '0;
        s_axis_tready = 1'b0;

        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                n_i = '0;
                if (s_axis_tvalid) begin
                    n_status  = ST_OK;
                    n_index   = '0;
                    n_matches = '0;
                    for (int k = 0; k < RepMonths; k++) n_sum[k] = '0;
                    n_tot = '0;
                    n_state = (s_axis_tdata[2:0] > 3'(ACT_CARR)) ? S_OUT : S_SCAN;
                end
            end
            // key read issued for entry r_i, result checked in the next cycle
            S_SCAN: begin
                if (r_kv && kmatch) begin
                    if (r_act == ACT_ADD) begin
                        if (mon_ok) begin
                            n_index = 8'(r_kidx);
                            n_state = S_ADD_RD;
                        end else begin
                            n_status = ST_BADMO;
                            n_state  = S_OUT;
                        end
                    end else begin
                        n_matches = r_matches + 9'd1;
                        n_m = '0;
                        n_state = S_SUM_RD;
                    end
                end else if (r_i < r_used) begin
                    n_kv   = 1'b1;
                    n_kidx = r_i[IdxW-1:0];
                    n_i    = r_i + UsedW'(1);
                end else if (r_act == ACT_ADD) begin
                    if (r_used == UsedW'(TableDepth)) begin
                        n_status = ST_FULL;
                        n_state  = S_OUT;
                    end else if (!mon_ok) begin
                        n_status = ST_BADMO;
                        n_state  = S_OUT;
                    end else begin
                        k_we    = 1'b1;
                        k_addr  = r_used[IdxW-1:0];
                        n_kidx  = r_used[IdxW-1:0];
                        n_index = 8'(r_used);
                        n_status = ST_NEW;
                        n_m = '0;
                        n_state = S_NEW_WR;
                    end
                end else begin
                    n_state = S_TOTAL;
                end
            end
            S_ADD_RD: begin
                c_addr  = ebase + CAW'(r_mon - 4'd1);
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                c_addr  = ebase + CAW'(r_mon - 4'd1);
                sadd    = {1'b0, c_rdata} + {9'd0, r_pax};
                c_we    = 1'b1;
                c_wdata = sadd[CntW] ? '1 : sadd[CntW-1:0];
                n_state = S_OUT;
            end
            S_NEW_WR: begin
                c_we    = 1'b1;
                c_wdata = (MW'(r_mon - 4'd1) == r_m) ? {8'd0, r_pax} : '0;
                n_m     = r_m + MW'(1);
                if (r_m == MW'(Months - 1)) begin
                    n_used  = r_used + UsedW'(1);
                    n_state = S_OUT;
                end
            end
            // read month r_m of matched entry
            S_SUM_RD: begin
                n_state = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                c_addr = ebase + CAW'(r_m);
                for (int k = 0; k < RepMonths; k++) begin
                    if (MW'(k) == r_m) cur = r_sum[k];
                end
                sadd = {1'b0, cur} + {1'b0, c_rdata};
                for (int k = 0; k < RepMonths; k++) begin
                    if (MW'(k) == r_m) n_sum[k] = sadd[CntW] ? '1 : sadd[CntW-1:0];
                end
                if (r_m == MW'(Months - 1)) begin
                    k_addr  = r_i[IdxW-1:0];
                    n_state = S_SCAN;
                end else begin
                    n_m = r_m + MW'(1);
                    c_addr = ebase + CAW'(r_m + MW'(1));
                    n_state = S_SUM_ACC;
                    n_kv = 1'b0;
                end
            end
            S_TOTAL: begin
                n_tot = TotW'(r_sum[0]) + TotW'(r_sum[1]) + TotW'(r_sum[2])
                      + TotW'(r_sum[3]) + TotW'(r_sum[4]) + TotW'(r_sum[5]);
                n_rem = '0;
                n_quo = n_tot;
                n_dc  = 6'(DivSteps);
                n_state = S_DIV;
            end
            // long division by 6, one 7-bit digit per cycle from the top
            S_DIV: begin
                dtry  = {r_rem, r_quo[TotW-1 -: DivChunk]};
                dprod = 20'(dtry) * 20'(DivMul);
                dq    = dprod[DivShift +: DivChunk];
                n_rem = 3'(dtry - 10'(dq) * 10'(DivDen));
                n_quo = {r_quo[TotW-DivChunk-1:0], dq};
                n_dc  = r_dc - 6'd1;
                if (r_dc == 6'd1) n_state = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                if (r_ovalid && m_axis_tready) begin
                    n_ovalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic [TotW-1:0] avg;
    assign avg = (r_act == ACT_ADD || r_act > 3'(ACT_CARR)) ? '0 : r_quo;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'd0, avg[CntW-1:0], r_tot,
                            r_sum[5], r_sum[4], r_sum[3], r_sum[2], r_sum[1], r_sum[0],
                            r_matches, r_index, r_status};
endmodule
